// ===== rtl/core/mcs_pkg.sv =====
// Shared types and constants of the maximum clique search core.
package mcs_pkg;

  // Built maximum vertex count and fixed field widths
  localparam int unsigned MaxVerticesDef = 32;
  localparam int unsigned RowW           = 32;
  localparam int unsigned IdxW           = 5;
  localparam int unsigned CfgW           = 6;
  localparam int unsigned SizeW          = 6;

  localparam logic [CfgW-1:0] VertexCountRst = 6'd5;

  // Branch progress codes kept per search level
  localparam logic [1:0] BrInclude = 2'd0;
  localparam logic [1:0] BrExclude = 2'd1;
  localparam logic [1:0] BrReturn  = 2'd2;

  // Row store write port
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [RowW-1:0] data;
  } row_wr_t;

  // Search sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_DONE  = 4'b1000
  } srch_state_e;

endpackage

// ===== rtl/core/max_clique_search_core.sv =====
// Top level of the maximum clique search core: row intake, config register, result word.
//
// Adjacency rows load one word per cycle into a row store. The word marked last
// starts a depth-first backtracking search over vertices 0 to vertex_count-1,
// the count capped at MAX_VERTICES (include branch first, exclude branch pruned
// by the size bound); the input is stalled until the search is over and its
// result has moved to the output register. Each step of the search tree reads the
// row store and branch stack memories at the current level in a fetch state,
// then evaluates and writes back in an execute state. A node below the last
// level costs at most three steps (include, exclude, return) and a leaf one.
// One result word then carries the best clique's bitmap and size; it sits in
// an output register so that rows for the next graph can load while it waits.
module max_clique_search_core #(
  parameter int unsigned MAX_VERTICES = mcs_pkg::MaxVerticesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mcs_pkg::CfgW-1:0]  cfg_data_i,
  // Row input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mcs_pkg::IdxW-1:0]  row_index_i,
  input  logic [mcs_pkg::RowW-1:0]  row_bits_i,
  input  logic                      last_row_i,
  // Result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mcs_pkg::RowW-1:0]  clique_bits_o,
  output logic [mcs_pkg::SizeW-1:0] clique_size_o
);
  import mcs_pkg::*;

  localparam int unsigned LvlW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  logic [CfgW-1:0]         vertex_count_q;
  logic [CntW-1:0]         n_sat;
  logic                    in_accept;
  row_wr_t                 row_wr;
  logic                    srch_busy;
  logic                    srch_done;
  logic                    srch_ack;
  logic [MAX_VERTICES-1:0] best_set;
  logic [CntW-1:0]         best_size;
  logic [RowW-1:0]         bits_ext;
  logic [SizeW-1:0]        size_ext;

  logic                    out_valid_q, out_valid_d;
  logic [RowW-1:0]         clique_bits_q;
  logic [SizeW-1:0]        clique_size_q;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VertexCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // Saturate the vertex count to the built store depth
  assign n_sat = (int'(vertex_count_q) > MAX_VERTICES) ? CntW'(MAX_VERTICES)
                                                       : CntW'(vertex_count_q);

  // Accept rows whenever the search is idle
  assign in_stall_o  = srch_busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign row_wr.en   = in_accept;
  assign row_wr.idx  = row_index_i;
  assign row_wr.data = row_bits_i;

  mcs_search #(
    .MAX_VERTICES (MAX_VERTICES),
    .LVL_W        (LvlW),
    .CNT_W        (CntW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_wr_i    (row_wr),
    .start_i     (in_accept && last_row_i),
    .n_i         (n_sat),
    .ack_i       (srch_ack),
    .busy_o      (srch_busy),
    .done_o      (srch_done),
    .best_set_o  (best_set),
    .best_size_o (best_size)
  );

  // Fit the best set and size to the result word
  for (genvar j = 0; j < RowW; j++) begin : g_bits
    if (j < MAX_VERTICES) begin : g_in
      assign bits_ext[j] = best_set[j];
    end else begin : g_out
      assign bits_ext[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < SizeW; j++) begin : g_size
    if (j < CntW) begin : g_in
      assign size_ext[j] = best_size[j];
    end else begin : g_out
      assign size_ext[j] = 1'b0;
    end
  end

  // Take the result once the output register is free
  assign srch_ack = srch_done && !out_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (srch_ack) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result word while stalled
  always_ff @(posedge clk_i) begin
    if (srch_ack) begin
      clique_bits_q <= bits_ext;
      clique_size_q <= size_ext;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clique_bits_o = clique_bits_q;
  assign clique_size_o = clique_size_q;

endmodule

// ===== rtl/core/mcs_search.sv =====
// Row store, branch stack memory and backtracking search sequencer.
module mcs_search #(
  parameter int unsigned MAX_VERTICES = mcs_pkg::MaxVerticesDef,
  parameter int unsigned LVL_W        = $clog2(MAX_VERTICES),
  parameter int unsigned CNT_W        = $clog2(MAX_VERTICES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mcs_pkg::row_wr_t        row_wr_i,
  input  logic                    start_i,
  input  logic [CNT_W-1:0]        n_i,
  input  logic                    ack_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [MAX_VERTICES-1:0] best_set_o,
  output logic [CNT_W-1:0]        best_size_o
);
  import mcs_pkg::*;

  srch_state_e state_q, state_d;

  logic [CNT_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]        level_q, level_d;
  logic [CNT_W-1:0]        size_q, size_d;
  logic [CNT_W-1:0]        best_size_q, best_size_d;
  logic [MAX_VERTICES-1:0] cur_q, cur_d;
  logic [MAX_VERTICES-1:0] best_q, best_d;
  logic                    fresh_q, fresh_d;

  logic [RowW-1:0] row_mem [MAX_VERTICES];
  logic [1:0]      stk_mem [MAX_VERTICES];
  logic [RowW-1:0] row_rd_q;
  logic [1:0]      stk_rd_q;

  logic              row_we;
  logic [LVL_W-1:0]  row_waddr;
  logic              rd_en;
  logic              stk_we;
  logic [1:0]        stk_wdata;
  logic [LVL_W-1:0]  lvl_idx;

  logic [MAX_VERTICES-1:0] row_ext;
  logic [MAX_VERTICES-1:0] lvl_bit;
  logic [1:0]              branch;
  logic                    fits;
  logic                    cur_has;
  logic [CNT_W-1:0]        size_x;
  logic [CNT_W-1:0]        remain;
  logic [CNT_W:0]          bound;

  // Row store write from the input side
  assign row_we    = row_wr_i.en && (int'(row_wr_i.idx) < MAX_VERTICES);
  assign row_waddr = LVL_W'(row_wr_i.idx);
  assign lvl_idx   = level_q[LVL_W-1:0];
  assign rd_en     = (state_q == S_FETCH) && (level_q < n_q);

  // Row store: one write port, one registered read
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wr_i.data;
    end
    if (rd_en) begin
      row_rd_q <= row_mem[lvl_idx];
    end
  end

  // Branch stack: written in evaluate, read in fetch, never both at once
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[lvl_idx] <= stk_wdata;
    end
    if (rd_en) begin
      stk_rd_q <= stk_mem[lvl_idx];
    end
  end

  // Widen the stored row to the vertex range; high vertices have no row bits
  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_row_ext
    if (j < RowW) begin : g_in
      assign row_ext[j] = row_rd_q[j];
    end else begin : g_out
      assign row_ext[j] = 1'b0;
    end
  end

  assign lvl_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << lvl_idx;
  assign branch  = fresh_q ? BrInclude : stk_rd_q;
  assign fits    = (cur_q & ~row_ext) == '0;
  assign cur_has = (cur_q & lvl_bit) != '0;
  assign size_x  = cur_has ? size_q - CNT_W'(1) : size_q;
  assign remain  = n_q - level_q - CNT_W'(1);
  assign bound   = {1'b0, size_x} + {1'b0, remain};

  // Search step sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    level_d     = level_q;
    size_d      = size_q;
    best_size_d = best_size_q;
    cur_d       = cur_q;
    best_d      = best_q;
    fresh_d     = fresh_q;
    stk_we      = 1'b0;
    stk_wdata   = BrInclude;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d         = n_i;
          level_d     = '0;
          size_d      = '0;
          best_size_d = '0;
          cur_d       = '0;
          best_d      = '0;
          fresh_d     = 1'b1;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FETCH;
        if (level_q >= n_q) begin
          // Leaf: take the current set as best, then back up
          best_d      = cur_q;
          best_size_d = size_q;
          fresh_d     = 1'b0;
          if (level_q == '0) begin
            state_d = S_DONE;
          end else begin
            level_d = level_q - CNT_W'(1);
          end
        end else begin
          unique case (branch)
            BrInclude: begin
              stk_we    = 1'b1;
              stk_wdata = BrExclude;
              fresh_d   = 1'b0;
              if (fits) begin
                cur_d   = cur_q | lvl_bit;
                size_d  = size_q + CNT_W'(1);
                level_d = level_q + CNT_W'(1);
                fresh_d = 1'b1;
              end
            end
            BrExclude: begin
              stk_we    = 1'b1;
              stk_wdata = BrReturn;
              cur_d     = cur_q & ~lvl_bit;
              size_d    = size_x;
              fresh_d   = 1'b0;
              // Prune unless the remaining vertices can still reach the best
              if (bound >= {1'b0, best_size_q}) begin
                level_d = level_q + CNT_W'(1);
                fresh_d = 1'b1;
              end
            end
            default: begin
              fresh_d = 1'b0;
              if (level_q == '0) begin
                state_d = S_DONE;
              end else begin
                level_d = level_q - CNT_W'(1);
              end
            end
          endcase
        end
        // Leave the working set clear once the search ends
        if (state_d == S_DONE) begin
          cur_d   = '0;
          size_d  = '0;
          level_d = '0;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      level_q     <= '0;
      size_q      <= '0;
      best_size_q <= '0;
      cur_q       <= '0;
      best_q      <= '0;
      fresh_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      level_q     <= level_d;
      size_q      <= size_d;
      best_size_q <= best_size_d;
      cur_q       <= cur_d;
      best_q      <= best_d;
      fresh_q     <= fresh_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign best_set_o  = best_q;
  assign best_size_o = best_size_q;

endmodule
